// ===== src/banked_rom_mapper_with_sram_port_defines.svh =====
// Assertion macros for the banked ROM mapper.
// Included by the top level; no other dependencies.
`ifndef BANKED_ROM_MAPPER_WITH_SRAM_PORT_DEFINES_SVH
`define BANKED_ROM_MAPPER_WITH_SRAM_PORT_DEFINES_SVH

`ifndef SYNTH
`define BRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BRM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRM_ASSERT(lbl, prop, msg)
`define BRM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/brm_pkg.sv =====
// Shared types and constants for the banked ROM mapper.
// No dependencies.
package brm_pkg;

    localparam int SRAM_DEPTH = 4096;
    localparam int SRAM_AW    = $clog2(SRAM_DEPTH);
    localparam int PTR_W      = 24;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_PEEK  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [1:0] SRC_DONE     = 2'd0;
    localparam logic [1:0] SRC_ROM      = 2'd1;
    localparam logic [1:0] SRC_READBACK = 2'd2;
    localparam logic [1:0] SRC_SRAM     = 2'd3;

    localparam logic [15:0] ADDR_BANK1   = 16'h6000;
    localparam logic [15:0] ADDR_BANK0   = 16'h6400;
    localparam logic [15:0] ADDR_BANK2   = 16'h7000;
    localparam logic [15:0] ADDR_BANK3   = 16'h7400;
    localparam logic [15:0] ADDR_CONTROL = 16'h7FF9;
    localparam logic [15:0] RB_MASK      = 16'h7FF9;
    localparam logic [15:0] RB_MATCH     = 16'h7FF0;

    localparam logic [13:0] OFS_PTR_HI  = 14'h3FFA;
    localparam logic [13:0] OFS_PTR_MID = 14'h3FFB;
    localparam logic [13:0] OFS_PTR_LO  = 14'h3FFC;
    localparam logic [13:0] OFS_SRAM    = 14'h3FFD;

    localparam int CTRL_SRAM_BIT = 1;
    localparam int CTRL_RB_BIT   = 2;

    typedef struct packed {
        logic [1:0]  source;
        logic [7:0]  read_data;
        logic [7:0]  rom_block;
        logic [13:0] rom_offset;
    } item_t;

    typedef struct packed {
        logic               en;
        logic               we;
        logic [SRAM_AW-1:0] addr;
        logic [7:0]         wdata;
    } ram_req_t;

    typedef struct packed {
        logic clearing;
        logic fire;
    } front_stat_t;

    typedef struct packed {
        logic           room;
        logic           stage_valid;
        logic [QCW-1:0] count;
    } back_stat_t;

endpackage

// ===== src/brm_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module brm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/brm_front.sv =====
// Front end: accepts bus accesses, classifies them, updates mapper state
// and issues SRAM requests. Depends on brm_pkg.
module brm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          kind,
    input  logic [15:0]         address,
    input  logic [7:0]          write_data,
    input  logic                room,
    output logic                item_valid,
    output brm_pkg::item_t      item,
    output brm_pkg::ram_req_t   ram_req,
    output brm_pkg::front_stat_t stat
);
    import brm_pkg::*;

    logic [7:0]       ctrl_reg, ctrl_next;
    logic [7:0]       bank_reg  [4];
    logic [7:0]       bank_next [4];
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [SRAM_AW:0] clr_reg, clr_next;

    logic        clearing;
    logic        fire;
    logic        is_write;
    logic        is_read;
    logic        sram_on;
    logic        rb_hit;
    logic [13:0] low;
    logic [1:0]  bank_sel;
    logic [7:0]  bank_val;

    assign clearing = ~clr_reg[SRAM_AW];
    assign s_tready = ~clearing & room;
    assign fire     = s_tvalid & s_tready;
    assign is_write = (kind == KIND_WRITE);
    assign is_read  = (kind == KIND_READ);
    assign low      = address[13:0];
    assign sram_on  = ctrl_reg[CTRL_SRAM_BIT];
    assign rb_hit   = ctrl_reg[CTRL_RB_BIT] && ((address & RB_MASK) == RB_MATCH);
    assign bank_sel = rb_hit ? address[2:1] : address[15:14];
    assign bank_val = bank_reg[bank_sel];

    always_comb
    begin
        ctrl_next = ctrl_reg;
        bank_next = bank_reg;
        ptr_next  = ptr_reg;
        clr_next  = clr_reg;
        item      = '0;
        ram_req   = '0;
        if (clearing)
        begin
            ram_req.en   = 1'b1;
            ram_req.we   = 1'b1;
            ram_req.addr = clr_reg[SRAM_AW-1:0];
            clr_next     = clr_reg + 1'b1;
        end
        if (is_write)
        begin
            item.source = SRC_DONE;
            if (address == ADDR_BANK1)
            begin
                bank_next[1] = write_data;
            end
            else if (address == ADDR_BANK0)
            begin
                bank_next[0] = write_data;
            end
            else if (address == ADDR_BANK2)
            begin
                bank_next[2] = write_data;
            end
            else if (address == ADDR_BANK3)
            begin
                bank_next[3] = write_data;
            end
            else if (address == ADDR_CONTROL)
            begin
                ctrl_next = write_data;
            end
            else if (sram_on)
            begin
                if (low == OFS_PTR_HI)
                begin
                    ptr_next[23:16] = write_data;
                end
                else if (low == OFS_PTR_MID)
                begin
                    ptr_next[15:8] = write_data;
                end
                else if (low == OFS_PTR_LO)
                begin
                    ptr_next[7:0] = write_data;
                end
                else if (low == OFS_SRAM)
                begin
                    ram_req.en    = fire;
                    ram_req.we    = 1'b1;
                    ram_req.addr  = ptr_reg[SRAM_AW-1:0];
                    ram_req.wdata = write_data;
                    ptr_next      = ptr_reg + 1'b1;
                end
            end
        end
        else
        begin
            priority if (rb_hit)
            begin
                item.source    = SRC_READBACK;
                item.read_data = bank_val;
            end
            else if (sram_on && (low == OFS_SRAM))
            begin
                item.source  = SRC_SRAM;
                ram_req.en   = fire;
                ram_req.addr = ptr_reg[SRAM_AW-1:0];
                if (is_read)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            else
            begin
                item.source     = SRC_ROM;
                item.rom_block  = bank_val;
                item.rom_offset = low;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            bank_reg <= '{default: '0};
            ptr_reg  <= '0;
            clr_reg  <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
            if (fire)
            begin
                ctrl_reg <= ctrl_next;
                bank_reg <= bank_next;
                ptr_reg  <= ptr_next;
            end
        end
    end

    assign item_valid    = fire;
    assign stat.clearing = clearing;
    assign stat.fire     = fire;

endmodule

// ===== src/brm_back.sv =====
// Back end: SRAM, result stage and result queue feeding the output.
// Depends on brm_pkg and brm_ram.
module brm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  brm_pkg::item_t      item,
    input  brm_pkg::ram_req_t   ram_req,
    output logic                m_tvalid,
    input  logic                m_tready,
    output brm_pkg::item_t      out_item,
    output brm_pkg::back_stat_t stat
);
    import brm_pkg::*;

    logic           stage_valid_reg;
    item_t          stage_item_reg;
    item_t          merged;
    logic [7:0]     ram_rdata;
    item_t          q_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] count_reg, count_next;
    logic [QCW:0]   pending;
    logic           push;
    logic           pop;

    brm_ram #(
        .WIDTH(8),
        .DEPTH(SRAM_DEPTH)
    ) u_sram (
        .clk  (clk),
        .en   (ram_req.en),
        .we   (ram_req.we),
        .addr (ram_req.addr),
        .wdata(ram_req.wdata),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        merged = stage_item_reg;
        if (stage_item_reg.source == SRC_SRAM)
        begin
            merged.read_data = ram_rdata;
        end
    end

    assign push       = stage_valid_reg;
    assign m_tvalid   = (count_reg != '0);
    assign pop        = m_tvalid & m_tready;
    assign out_item   = q_reg[rd_ptr_reg];
    assign count_next = count_reg + QCW'(push) - QCW'(pop);
    assign pending    = {1'b0, count_reg} + (QCW + 1)'(stage_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            stage_valid_reg <= item_valid;
            count_reg       <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid)
        begin
            stage_item_reg <= item;
        end
        if (push)
        begin
            q_reg[wr_ptr_reg] <= merged;
        end
    end

    assign stat.room        = (pending < (QCW + 1)'(QDEPTH));
    assign stat.stage_valid = stage_valid_reg;
    assign stat.count       = count_reg;

endmodule

// ===== src/banked_rom_mapper_with_sram_port.sv =====
// Channel   Dir  Ready  Payload
// s_*       in   yes    tuser: kind; tdata: address, write_data
// m_*       out  yes    tuser: source; tdata: read_data, rom_block, rom_offset
//
// One access accepted per cycle while s_tready is high; its result passes through the result stage into the queue.
// The SRAM is a single-port RAM: each access touches at most one entry.
// After reset a clearing pass zeroes every SRAM entry, with s_tready low.
// A four-entry result queue absorbs output stalls; s_tready drops once it has no room.
// Top level of the banked ROM mapper; depends on brm_pkg, brm_front, brm_back
// and the assertion macros in banked_rom_mapper_with_sram_port_defines.svh.
`include "banked_rom_mapper_with_sram_port_defines.svh"

module banked_rom_mapper_with_sram_port (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data[7:0], rom_block[15:8], rom_offset[29:16]
    output logic [1:0]  m_tuser    // source[1:0]
);
    import brm_pkg::*;

    logic         item_valid;
    item_t        item;
    item_t        out_item;
    ram_req_t     ram_req;
    front_stat_t  front_stat;
    back_stat_t   back_stat;
    logic [QCW:0] in_flight;

    brm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .kind      (s_tuser),
        .address   (s_tdata[15:0]),
        .write_data(s_tdata[23:16]),
        .room      (back_stat.room),
        .item_valid(item_valid),
        .item      (item),
        .ram_req   (ram_req),
        .stat      (front_stat)
    );

    brm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item      (item),
        .ram_req   (ram_req),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_item  (out_item),
        .stat      (back_stat)
    );

    assign m_tuser = out_item.source;
    assign m_tdata = {2'b00, out_item.rom_offset, out_item.rom_block, out_item.read_data};

    assign in_flight = {1'b0, back_stat.count} + (QCW + 1)'(back_stat.stage_valid);

    `BRM_ASSERT_ALWAYS(a_clear_blocks_input, front_stat.clearing |-> !s_tready, "accept in clear")
    `BRM_ASSERT(a_accept_reaches_stage, front_stat.fire |=> back_stat.stage_valid, "access lost")
    `BRM_ASSERT(a_queue_bound, in_flight <= (QCW + 1)'(QDEPTH), "result queue overrun")

endmodule

// ===== dv/banked_rom_mapper_with_sram_port_tb.sv =====
// Self-checking testbench for banked_rom_mapper_with_sram_port: directed and random bus
// accesses, a shadow copy of the mapper state predicts every reply.
// Depends on brm_pkg and the mapper RTL only.
module banked_rom_mapper_with_sram_port_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brm_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int CALM_ITEMS = 300;
    localparam int BUSY_ITEMS = 1225;

    class mapper_shadow;
        logic [7:0]       control;
        logic [7:0]       banks [4];
        logic [PTR_W-1:0] pointer;
        logic [7:0]       sram_image [SRAM_DEPTH];
        item_t            expected_replies [$];
        int               errors;

        function new();
            control = '0;
            pointer = '0;
            errors = 0;
            foreach (banks[i]) banks[i] = '0;
            foreach (sram_image[i]) sram_image[i] = '0;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void note_access(logic [1:0] kind, logic [15:0] addr, logic [7:0] wd);
            item_t      reply;
            logic [13:0] ofs;
            logic        sram_on;
            reply = '0;
            ofs = addr[13:0];
            sram_on = control[CTRL_SRAM_BIT];
            if (kind == KIND_WRITE)
            begin
                reply.source = SRC_DONE;
                if (addr == ADDR_BANK1)
                    banks[1] = wd;
                else if (addr == ADDR_BANK0)
                    banks[0] = wd;
                else if (addr == ADDR_BANK2)
                    banks[2] = wd;
                else if (addr == ADDR_BANK3)
                    banks[3] = wd;
                else if (addr == ADDR_CONTROL)
                    control = wd;
                else if (sram_on)
                begin
                    if (ofs == OFS_PTR_HI)
                        pointer[23:16] = wd;
                    else if (ofs == OFS_PTR_MID)
                        pointer[15:8] = wd;
                    else if (ofs == OFS_PTR_LO)
                        pointer[7:0] = wd;
                    else if (ofs == OFS_SRAM)
                    begin
                        sram_image[pointer % SRAM_DEPTH] = wd;
                        pointer = pointer + 1'b1;
                    end
                end
            end
            else if (control[CTRL_RB_BIT] && (addr & RB_MASK) == RB_MATCH)
            begin
                reply.source = SRC_READBACK;
                reply.read_data = banks[addr[2:1]];
            end
            else if (sram_on && ofs == OFS_SRAM)
            begin
                reply.source = SRC_SRAM;
                reply.read_data = sram_image[pointer % SRAM_DEPTH];
                if (kind == KIND_READ)
                    pointer = pointer + 1'b1;
            end
            else
            begin
                reply.source = SRC_ROM;
                reply.rom_block = banks[addr[15:14]];
                reply.rom_offset = ofs;
            end
            expected_replies.push_back(reply);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(logic [1:0] src, logic [31:0] data);
            item_t want;
            if (expected_replies.size() == 0)
            begin
                $error("reply with no request pending: source %0d data 0x%0h", src, data);
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            check_field("source", want.source, src);
            check_field("read_data", want.read_data, data[7:0]);
            check_field("rom_block", want.rom_block, data[15:8]);
            check_field("rom_offset", want.rom_offset, data[29:16]);
        endfunction

        function void check_drained();
            if (expected_replies.size() != 0)
            begin
                $error("%0d replies never arrived", expected_replies.size());
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    int          idle_pct = 34;
    int          stall_pct = 34;
    int          cycles = 0;
    mapper_shadow shadow = new();

    banked_rom_mapper_with_sram_port i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            shadow.check_reply(m_tuser, m_tdata);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("banked_rom_mapper_with_sram_port: mismatch");
            $finish;
        end
    end

    task automatic send(logic [1:0] kind, logic [15:0] addr, logic [7:0] wd);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {wd, addr};
        do @(posedge clk); while (!s_tready);
        shadow.note_access(kind, addr, wd);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (shadow.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [1:0] read_kind();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
            return KIND_READ;
        else if (pick < 9)
            return KIND_PEEK;
        return KIND_SPARE;
    endfunction

    task automatic random_access();
        int          pick;
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  wd;
        pick = $urandom_range(99);
        kind = read_kind();
        addr = 16'($urandom);
        wd = 8'($urandom);
        if (pick < 20)
        begin
            kind = KIND_WRITE;
            case ($urandom_range(3))
                0: addr = ADDR_BANK0;
                1: addr = ADDR_BANK1;
                2: addr = ADDR_BANK2;
                default: addr = ADDR_BANK3;
            endcase
        end
        else if (pick < 26)
        begin
            kind = KIND_WRITE;
            addr = ADDR_CONTROL;
            if ($urandom_range(9) < 7)
                wd = wd | 8'h06;
        end
        else if (pick < 36)
        begin
            kind = KIND_WRITE;
            addr = {addr[15:14], OFS_PTR_HI + 14'($urandom_range(2))};
        end
        else if (pick < 54)
        begin
            addr = {addr[15:14], OFS_SRAM};
            if ($urandom_range(1) == 1)
                kind = KIND_WRITE;
        end
        else if (pick < 64)
        begin
            addr = (addr & ~RB_MASK) | RB_MATCH;
        end
        else if (pick < 70)
        begin
            kind = KIND_WRITE;
        end
        send(kind, addr, wd);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send(KIND_READ, 16'h0000, 8'h00);
        send(KIND_PEEK, 16'hFFFF, 8'hFF);
        send(KIND_WRITE, ADDR_BANK1, 8'hA5);
        send(KIND_WRITE, ADDR_BANK0, 8'h5A);
        send(KIND_WRITE, ADDR_BANK2, 8'hFF);
        send(KIND_WRITE, ADDR_BANK3, 8'h3C);
        send(KIND_READ, 16'h0123, 8'h00);
        send(KIND_READ, 16'h4567, 8'h00);
        send(KIND_PEEK, 16'h89AB, 8'h00);
        send(KIND_SPARE, 16'hC000, 8'h00);
        send(KIND_WRITE, ADDR_CONTROL, 8'h06);
        send(KIND_PEEK, 16'h7FF0, 8'h00);
        send(KIND_READ, 16'h7FF2, 8'h00);
        send(KIND_SPARE, 16'hFFF6, 8'h00);
        send(KIND_WRITE, 16'h3FFA, 8'hFF);
        send(KIND_WRITE, 16'h7FFB, 8'hFF);
        send(KIND_WRITE, 16'hBFFC, 8'hFF);
        send(KIND_WRITE, 16'hFFFD, 8'h77);
        send(KIND_READ, 16'h3FFD, 8'h00);
        send(KIND_WRITE, 16'h3FFB, 8'h0F);
        send(KIND_PEEK, 16'h3FFD, 8'h00);
        send(KIND_SPARE, 16'h7FFD, 8'h00);
        send(KIND_WRITE, 16'h1234, 8'hEE);
        send(KIND_WRITE, ADDR_CONTROL, 8'h00);
        send(KIND_WRITE, 16'h3FFD, 8'h11);

        idle_pct = 0;
        stall_pct = 0;
        repeat (CALM_ITEMS) random_access();
        drain();

        idle_pct = 34;
        stall_pct = 34;
        repeat (BUSY_ITEMS / 2) random_access();
        drain();
        repeat (BUSY_ITEMS - BUSY_ITEMS / 2) random_access();
        s_tvalid <= 1'b0;

        while (shadow.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        shadow.check_drained();
        if (shadow.errors == 0)
            $display("banked_rom_mapper_with_sram_port: match");
        else
            $display("banked_rom_mapper_with_sram_port: mismatch");
        $finish;
    end
endmodule
